[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
// Depends on nothing; each macro takes a label, a clock, a reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define CHK_IMPL(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("same-cycle check failed");
// next-cycle implication
`define CHK_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");
`endif

[hdl/glrp_pkg.sv]
// Shared types and constants of the load rebalance planner.
// Depends on nothing.
package glrp_pkg;
   localparam int MAX_CHUNKS_DEF = 16;
   localparam int BIN_W          = 16;
   localparam int OUT_IDX_W      = 4;

   typedef struct packed {
      logic [BIN_W-1:0] bin_count;
      logic             last_bin;
   } req_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] source_bin;
      logic [OUT_IDX_W-1:0] dest_bin;
      logic [BIN_W-1:0]     move_amount;
      logic                 plan_done;
   } rsp_type;

   typedef enum logic [16:0] {
      S_IDLE  = 17'h00001,
      S_DIV   = 17'h00002,
      S_RK_I  = 17'h00004,
      S_RK_IW = 17'h00008,
      S_RK_J  = 17'h00010,
      S_RK_JW = 17'h00020,
      S_RK_WR = 17'h00040,
      S_WK_O  = 17'h00080,
      S_WK_OW = 17'h00100,
      S_WK_S  = 17'h00200,
      S_WK_SW = 17'h00400,
      S_WK_D  = 17'h00800,
      S_WK_DW = 17'h01000,
      S_WK_Z  = 17'h02000,
      S_WK_ZW = 17'h04000,
      S_FIN   = 17'h08000,
      S_SPARE = 17'h10000
   } state_type;
endpackage

[hdl/greedy_load_rebalance_planner.sv]
// Greedy load rebalance planner: loads bin counts, sorts them, plans moves.
// A bin without the last flag is taken and the planner stays idle. A last bin starts a plan:
// a divider splits the total over the bins (TOT_W = BIN_W + clog2(N+1) bits), the bins are
// ranked over the single size memory read port, then each source is walked over its
// destinations; busy stays high meanwhile, one set at a time.
// Results are strobed one per cycle at most, the last one after busy drops; the receiver
// cannot stall. Reset is synchronous: the load and move counters and control clear; memories are not cleared.
module greedy_load_rebalance_planner
   import glrp_pkg::*;
#(
   parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_valid,
   output rsp_type rsp_word
);
   localparam int IDX_W     = $clog2(MAX_CHUNKS);
   localparam int CNT_W     = $clog2(MAX_CHUNKS + 1);
   localparam int TOT_W     = BIN_W + CNT_W;
   localparam int RES_LIMIT = 2 * MAX_CHUNKS - 3;
   localparam int K_W       = $clog2(RES_LIMIT + 1);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] loaded_ff, loaded_in, extra_ff, extra_in;
   logic [TOT_W-1:0] total_ff, total_in, base_ff, base_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [IDX_W-1:0] rank_ff, rank_in, src_ff, src_in, dst_ff, dst_in;
   logic [BIN_W-1:0] si_ff, si_in, surplus_ff, surplus_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic             pend_v_ff, pend_v_in, rsp_valid_ff, rsp_valid_in;
   rsp_type          pend_ff, pend_in, rsp_ff, rsp_in;

   logic [BIN_W-1:0] size_mem [MAX_CHUNKS];
   logic [IDX_W-1:0] order_mem [MAX_CHUNKS];
   logic [BIN_W-1:0] size_rd_ff, size_wd;
   logic [IDX_W-1:0] size_ra, size_wa, order_rd_ff, order_ra, order_wa, order_wd;
   logic             size_we, order_we;

   logic             div_go, div_done;
   logic [TOT_W-1:0] div_quo;
   logic [CNT_W-1:0] div_rem;

   logic [TOT_W-1:0] tgt, sz, deficit;
   logic [BIN_W-1:0] amt;
   logic             accept;

   glrp_div #(.DD_W(TOT_W), .DV_W(CNT_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .go        (div_go),
      .dividend  (total_in),
      .divisor   (loaded_in),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign accept = start && (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      loaded_in    = loaded_ff;
      total_in     = total_ff;
      base_in      = base_ff;
      extra_in     = extra_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      rank_in      = rank_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      si_in        = si_ff;
      surplus_in   = surplus_ff;
      k_in         = k_ff;
      pend_v_in    = pend_v_ff;
      pend_in      = pend_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      size_we      = 1'b0;
      size_wa      = loaded_ff[IDX_W-1:0];
      size_wd      = req_word.bin_count;
      size_ra      = i_ff[IDX_W-1:0];
      order_we     = 1'b0;
      order_wa     = rank_ff;
      order_wd     = i_ff[IDX_W-1:0];
      order_ra     = i_ff[IDX_W-1:0];
      div_go       = 1'b0;
      sz           = TOT_W'(size_rd_ff);
      tgt          = base_ff + TOT_W'(i_ff < extra_ff);
      deficit      = '0;
      amt          = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (loaded_ff < CNT_W'(MAX_CHUNKS)) begin
                  size_we   = 1'b1;
                  total_in  = total_ff + TOT_W'(req_word.bin_count);
                  loaded_in = loaded_ff + 1'b1;
               end
               if (req_word.last_bin) begin
                  div_go   = 1'b1;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               base_in  = div_quo;
               extra_in = div_rem;
               i_in     = '0;
               state_in = S_RK_I;
            end
         end
         S_RK_I: begin
            state_in = S_RK_IW;
         end
         S_RK_IW: begin
            si_in    = size_rd_ff;
            j_in     = '0;
            rank_in  = '0;
            state_in = S_RK_J;
         end
         S_RK_J: begin
            size_ra  = j_ff[IDX_W-1:0];
            state_in = S_RK_JW;
         end
         S_RK_JW: begin
            // earlier loads win ties
            if (size_rd_ff > si_ff || (size_rd_ff == si_ff && j_ff < i_ff))
               rank_in = rank_ff + 1'b1;
            j_in     = j_ff + 1'b1;
            state_in = (j_ff + 1'b1 == loaded_ff) ? S_RK_WR : S_RK_J;
         end
         S_RK_WR: begin
            order_we = 1'b1;
            i_in     = i_ff + 1'b1;
            if (i_ff + 1'b1 == loaded_ff) begin
               i_in     = '0;
               k_in     = '0;
               state_in = S_WK_O;
            end else begin
               state_in = S_RK_I;
            end
         end
         S_WK_O: begin
            state_in = (TOT_W'(i_ff) + 1'b1 >= TOT_W'(loaded_ff)) ? S_FIN : S_WK_OW;
         end
         S_WK_OW: begin
            src_in   = order_rd_ff;
            state_in = S_WK_S;
         end
         S_WK_S: begin
            size_ra  = src_ff;
            state_in = S_WK_SW;
         end
         S_WK_SW: begin
            if (sz <= tgt) begin
               i_in     = i_ff + 1'b1;
               state_in = S_WK_O;
            end else begin
               surplus_in = BIN_W'(sz - tgt);
               j_in       = i_ff + 1'b1;
               state_in   = S_WK_D;
            end
         end
         S_WK_D: begin
            order_ra = j_ff[IDX_W-1:0];
            if (surplus_ff == '0 || j_ff == loaded_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = S_WK_O;
            end else begin
               state_in = S_WK_DW;
            end
         end
         S_WK_DW: begin
            dst_in   = order_rd_ff;
            state_in = S_WK_Z;
         end
         S_WK_Z: begin
            size_ra  = dst_ff;
            state_in = S_WK_ZW;
         end
         S_WK_ZW: begin
            tgt  = base_ff + TOT_W'(j_ff < extra_ff);
            j_in = j_ff + 1'b1;
            if (sz < tgt) begin
               deficit = tgt - sz;
               amt     = (deficit < TOT_W'(surplus_ff)) ? BIN_W'(deficit) : surplus_ff;
               size_we = 1'b1;
               size_wa = dst_ff;
               size_wd = BIN_W'(sz + TOT_W'(amt));
               surplus_in = surplus_ff - amt;
               if (k_ff < K_W'(RES_LIMIT)) begin
                  // release the held word, hold the new one until the next move or end
                  rsp_valid_in = pend_v_ff;
                  rsp_in       = pend_ff;
                  pend_v_in    = 1'b1;
                  pend_in.source_bin  = OUT_IDX_W'(src_ff);
                  pend_in.dest_bin    = OUT_IDX_W'(dst_ff);
                  pend_in.move_amount = amt;
                  pend_in.plan_done   = 1'b0;
                  k_in = k_ff + 1'b1;
               end
            end
            state_in = S_WK_D;
         end
         S_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_in       = pend_v_ff ? pend_ff : '0;
            rsp_in.plan_done = 1'b1;
            pend_v_in    = 1'b0;
            loaded_in    = '0;
            total_in     = '0;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         loaded_ff    <= '0;
         total_ff     <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         total_ff     <= total_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
      end
      base_ff    <= base_in;
      extra_ff   <= extra_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      rank_ff    <= rank_in;
      src_ff     <= src_in;
      dst_ff     <= dst_in;
      si_ff      <= si_in;
      surplus_ff <= surplus_in;
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (size_we) size_mem[size_wa] <= size_wd;
      size_rd_ff <= size_mem[size_ra];
   end

   always_ff @(posedge clock) begin
      if (order_we) order_mem[order_wa] <= order_wd;
      order_rd_ff <= order_mem[order_ra];
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
endmodule

[hdl/glrp_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; widths come from the parameters.
module glrp_div #(
   parameter int DD_W = 21,
   parameter int DV_W = 5
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            go,
   input  logic [DD_W-1:0] dividend,
   input  logic [DV_W-1:0] divisor,
   output logic            done,
   output logic [DD_W-1:0] quotient,
   output logic [DV_W-1:0] remainder
);
   localparam int C_W = $clog2(DD_W + 1);

   logic [C_W-1:0]  cnt_ff, cnt_in;
   logic            run_ff, run_in, done_ff, done_in;
   logic [DD_W-1:0] quo_ff, quo_in;
   logic [DV_W-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [DV_W:0]   r2, diff;

   always_comb begin
      r2      = {rem_ff, quo_ff[DD_W-1]};
      diff    = r2 - {1'b0, dvs_ff};
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (go) begin
         run_in = 1'b1;
         cnt_in = C_W'(DD_W);
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         if (r2 >= {1'b0, dvs_ff}) begin
            rem_in = diff[DV_W-1:0];
            quo_in = {quo_ff[DD_W-2:0], 1'b1};
         end else begin
            rem_in = r2[DV_W-1:0];
            quo_in = {quo_ff[DD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == C_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

[hdl/glrp_checker.sv]
// Port-level checks of the planner, bound to the top level.
// Depends on glrp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module glrp_checker
   import glrp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_word,
   input logic    rsp_valid,
   input rsp_type rsp_word
);
   // a move word that is not the final one comes out while the plan still runs
   `CHK_IMPL(a_mid_busy, clock, reset, rsp_valid && !rsp_word.plan_done, busy)
   // a plan never ends two words in a row
   `CHK_NEXT(a_done_gap, clock, reset, rsp_valid && rsp_word.plan_done, !rsp_valid)
   // a bin without the last flag produces nothing
   `CHK_NEXT(a_load_quiet, clock, reset, start && !busy && !req_word.last_bin, !rsp_valid)
   // a last bin starts a plan
   `CHK_NEXT(a_plan_starts, clock, reset, start && !busy && req_word.last_bin, busy)
endmodule

bind greedy_load_rebalance_planner glrp_checker u_glrp_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_word  (rsp_word)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for the greedy load rebalance planner: sends bin sets, predicts the move plan
// of each set in a local model and checks every strobed move word. Depends on glrp_pkg.
module tb_top;
   import glrp_pkg::*;

   localparam int NBINS = MAX_CHUNKS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_valid;
   rsp_type rsp_word;

   logic [15:0] held_count[NBINS];
   int          held_num;
   rsp_type     pending_moves[$];
   int          failures;
   int          quiet_cycles;
   int          idle_pct;

   greedy_load_rebalance_planner uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word)
   );

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   // Work out the moves of one complete set and queue them.
   task automatic plan_moves();
      int      sz[NBINS];
      int      ord[NBINS];
      int      n, tot, base, extra, i, j, v, tgt, tj, surplus, deficit, m, emitted;
      rsp_type w;
      n = held_num;
      tot = 0;
      emitted = 0;
      for (i = 0; i < n; i++) begin
         sz[i] = int'(held_count[i]);
         tot += sz[i];
      end
      base = tot / n;
      extra = tot % n;
      // stable sort, largest first
      for (i = 0; i < n; i++) begin
         v = i;
         j = i;
         while (j > 0 && sz[ord[j-1]] < sz[v]) begin
            ord[j] = ord[j-1];
            j--;
         end
         ord[j] = v;
      end
      for (i = 0; i + 1 < n; i++) begin
         tgt = base + int'(i < extra);
         if (sz[ord[i]] <= tgt) continue;
         surplus = sz[ord[i]] - tgt;
         for (j = i + 1; surplus > 0 && j < n; j++) begin
            tj = base + int'(j < extra);
            if (sz[ord[j]] >= tj) continue;
            deficit = tj - sz[ord[j]];
            m = deficit < surplus ? deficit : surplus;
            if (emitted < 2 * NBINS - 3) begin
               w.source_bin = 4'(ord[i]);
               w.dest_bin = 4'(ord[j]);
               w.move_amount = 16'(m);
               w.plan_done = 1'b0;
               pending_moves = {pending_moves, w};
               emitted++;
            end
            sz[ord[i]] -= m;
            sz[ord[j]] += m;
            surplus -= m;
         end
      end
      if (emitted == 0) begin
         w = '0;
         pending_moves = {pending_moves, w};
      end
      pending_moves[pending_moves.size()-1].plan_done = 1'b1;
      held_num = 0;
   endtask

   // Send one bin word; idle at random beforehand.
   task automatic send_bin(input logic [15:0] cnt, input logic last);
      while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_word <= '{bin_count: cnt, last_bin: last};
      @(posedge clock);
      while (busy) @(posedge clock);
      if (held_num < NBINS) begin
         held_count[held_num] = cnt;
         held_num++;
      end
      if (last) plan_moves();
      @(negedge clock);
   endtask

   task automatic send_set(input int n, input int maxv);
      for (int i = 0; i < n; i++)
         send_bin(16'($urandom_range(maxv, 0)), i == n - 1);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_moves.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      send_bin(16'd0, 1'b1);                      // single bin
      send_bin(16'hFFFF, 1'b1);
      send_bin(16'd5, 1'b0); send_bin(16'd5, 1'b1); // already balanced
      send_bin(16'hFFFF, 1'b0); send_bin(16'd0, 1'b0); send_bin(16'd0, 1'b1);
      send_bin(16'd0, 1'b0); send_bin(16'd7, 1'b0);
      send_bin(16'd7, 1'b0); send_bin(16'd1, 1'b1); // ties keep load order
   endtask

   task automatic test_full_set();
      // full set of extremes, with an ignored bin beyond it
      for (int i = 0; i < NBINS; i++)
         send_bin((i % 2) ? 16'hFFFF : 16'h0000, 1'b0);
      send_bin(16'h1234, 1'b1);
      wait_drained();
      for (int i = 0; i < NBINS; i++)
         send_bin(16'($urandom_range(65535, 0)), i == NBINS - 1);
   endtask

   task automatic test_random();
      int sent;
      int n;
      sent = 0;
      while (sent < 76) begin
         n = ($urandom_range(9, 0) == 0) ? NBINS : int'($urandom_range(6, 1));
         idle_pct = (sent > 20 && sent < 50) ? 0 : 29;
         send_set(n, $urandom_range(1, 0) ? 65535 : 20);
         sent += n;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_moves.size() == 0) begin
               $display("%0t: unexpected move word, expected none actual %p", $time,
                  rsp_word);
               failures++;
            end else begin
               if (rsp_word !== pending_moves[0]) begin
                  $display("%0t: mismatch expected %p actual %p", $time,
                     pending_moves[0], rsp_word);
                  failures++;
               end
               void'(pending_moves.pop_front());
            end
         end
         if (rsp_valid || (start && !busy)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      failures = 0;
      quiet_cycles = 0;
      held_num = 0;
      idle_pct = 29;
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_set();
      wait_drained();   // hold the sender until every move is in
      test_random();
      wait_drained();
      repeat (50) @(negedge clock);
      if (failures == 0 && pending_moves.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
